// File: src/perceptron_window_trainer_unit_assert.svh
// Assertion macros shared by the trainer modules.
// Each macro samples on clk and is switched off while rst is high.
`ifndef PERCEPTRON_WINDOW_TRAINER_UNIT_ASSERT_SVH
`define PERCEPTRON_WINDOW_TRAINER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PWT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked on the following edge.
`define PWT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pwt_pkg.sv
// ----------------------------------------------------------------------------
// pwt_pkg
// Shared types, constants and helpers of the perceptron window trainer.
// ----------------------------------------------------------------------------
package pwt_pkg;

  localparam int NUM_WEIGHTS      = 10;
  localparam int NUM_PIX          = 9;
  localparam int PIX_WIDTH        = 8;
  localparam int LR_WIDTH         = 12;
  localparam int CFG_DATA_WIDTH   = 12;
  localparam int CFG_INDEX_WIDTH  = 2;
  localparam int DEF_WEIGHT_WIDTH = 20;

  localparam logic [PIX_WIDTH-1:0] THRESHOLD_RESET    = 8'd127;
  localparam logic [LR_WIDTH-1:0]  LEARN_RATE_RESET   = 12'd41;
  localparam logic                 TRAIN_ENABLE_RESET = 1'b1;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_THRESHOLD    = 2'd0,
    CFG_LEARN_RATE   = 2'd1,
    CFG_TRAIN_ENABLE = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [PIX_WIDTH-1:0] threshold_level;
    logic [LR_WIDTH-1:0]  learn_rate;
    logic                 train_enable;
  } cfg_t;

  // Binarised window: bits[k] feeds weight k+1.
  typedef struct packed {
    logic [NUM_PIX-1:0] bits;
    logic               goal;
    logic               epoch_end;
  } item_t;

  typedef struct packed {
    logic predicted;
    logic mismatch;
    logic epoch_had_error;
  } result_t;

  function automatic logic binarise(input logic [PIX_WIDTH-1:0] pix,
                                    input logic [PIX_WIDTH-1:0] level);
    return (pix > level);
  endfunction

endpackage

// File: src/perceptron_window_trainer_unit.sv
// ----------------------------------------------------------------------------
// perceptron_window_trainer_unit
// Perceptron on binarised 3x3 windows with on-line training.
//
//   channel  handshake             payload
//   cfg      cfg_we                cfg_index, cfg_data
//   in       in_valid / in_stall   pix_* (9), goal_pixel, epoch_end
//   out      out_valid / out_stall predicted, mismatch, epoch_had_error
//
// One word per cycle sustained while out_stall is low; each word passes the input register and the result register.
// The sum, prediction and weight update of a word fit between the input
// register and the result register, so the next word sees updated weights.
// Synchronous reset clears weights to zero and restores register defaults.
// A stalled result holds; the input register takes one more word if empty,
// then the input stalls until the result drains.
// ----------------------------------------------------------------------------
`include "perceptron_window_trainer_unit_assert.svh"

module perceptron_window_trainer_unit #(
  parameter int WEIGHT_WIDTH = pwt_pkg::DEF_WEIGHT_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [pwt_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [pwt_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [pwt_pkg::PIX_WIDTH-1:0]         pix_up_left,
  input  logic [pwt_pkg::PIX_WIDTH-1:0]         pix_up,
  input  logic [pwt_pkg::PIX_WIDTH-1:0]         pix_up_right,
  input  logic [pwt_pkg::PIX_WIDTH-1:0]         pix_left,
  input  logic [pwt_pkg::PIX_WIDTH-1:0]         pix_center,
  input  logic [pwt_pkg::PIX_WIDTH-1:0]         pix_right,
  input  logic [pwt_pkg::PIX_WIDTH-1:0]         pix_down_left,
  input  logic [pwt_pkg::PIX_WIDTH-1:0]         pix_down,
  input  logic [pwt_pkg::PIX_WIDTH-1:0]         pix_down_right,
  input  logic [pwt_pkg::PIX_WIDTH-1:0]         goal_pixel,
  input  logic                                  epoch_end,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  predicted,
  output logic                                  mismatch,
  output logic                                  epoch_had_error
);

  pwt_pkg::cfg_t    cfg;
  pwt_pkg::item_t   item;
  pwt_pkg::result_t res_comb;
  pwt_pkg::result_t res;
  logic [pwt_pkg::NUM_PIX-1:0][pwt_pkg::PIX_WIDTH-1:0] pix;
  logic             stage_valid;
  logic             fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_level <= pwt_pkg::THRESHOLD_RESET;
      cfg.learn_rate      <= pwt_pkg::LEARN_RATE_RESET;
      cfg.train_enable    <= pwt_pkg::TRAIN_ENABLE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pwt_pkg::CFG_THRESHOLD:
          cfg.threshold_level <= cfg_data[pwt_pkg::PIX_WIDTH-1:0];
        pwt_pkg::CFG_LEARN_RATE:
          cfg.learn_rate <= cfg_data[pwt_pkg::LR_WIDTH-1:0];
        pwt_pkg::CFG_TRAIN_ENABLE:
          cfg.train_enable <= cfg_data[0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // Window order matches weights 1..9.
  assign pix[0] = pix_up_left;
  assign pix[1] = pix_up;
  assign pix[2] = pix_up_right;
  assign pix[3] = pix_left;
  assign pix[4] = pix_center;
  assign pix[5] = pix_right;
  assign pix[6] = pix_down_left;
  assign pix[7] = pix_down;
  assign pix[8] = pix_down_right;

  // Advance the held word whenever the result register is free or draining.
  assign fire = stage_valid && (!out_valid || !out_stall);

  pwt_in_stage u_in_stage (
    .clk             (clk),
    .rst             (rst),
    .threshold_level (cfg.threshold_level),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .pix             (pix),
    .goal_pixel      (goal_pixel),
    .epoch_end       (epoch_end),
    .advance         (fire),
    .stage_valid     (stage_valid),
    .item            (item)
  );

  pwt_neuron #(
    .WEIGHT_WIDTH (WEIGHT_WIDTH)
  ) u_neuron (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (fire),
    .item (item),
    .res  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_comb;
    end
  end

  assign predicted       = res.predicted;
  assign mismatch        = res.mismatch;
  assign epoch_had_error = res.epoch_had_error;

  `PWT_ASSERT_NOW(a_no_overwrite, out_valid && out_stall, !fire, "result overwritten while stalled")
  `PWT_ASSERT_NOW(a_stall_needs_word, in_stall, stage_valid && out_valid && out_stall, "input stalled without a blocked word")
  `PWT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(res), "stalled result changed")

endmodule

// File: src/pwt_in_stage.sv
// ----------------------------------------------------------------------------
// pwt_in_stage
// Input register: binarises the window and goal pixel on capture.
// ----------------------------------------------------------------------------
module pwt_in_stage (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic [pwt_pkg::PIX_WIDTH-1:0]                threshold_level,
  input  logic                                         in_valid,
  output logic                                         in_stall,
  input  logic [pwt_pkg::NUM_PIX-1:0][pwt_pkg::PIX_WIDTH-1:0] pix,
  input  logic [pwt_pkg::PIX_WIDTH-1:0]                goal_pixel,
  input  logic                                         epoch_end,
  input  logic                                         advance,
  output logic                                         stage_valid,
  output pwt_pkg::item_t                               item
);

  logic           accept;
  pwt_pkg::item_t item_next;

  // Take a new word when the register is empty or the held one moves on in the same cycle.
  assign in_stall = stage_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    for (int k = 0; k < pwt_pkg::NUM_PIX; k++) begin
      item_next.bits[k] = pwt_pkg::binarise(pix[k], threshold_level);
    end
    item_next.goal      = pwt_pkg::binarise(goal_pixel, threshold_level);
    item_next.epoch_end = epoch_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

// File: src/pwt_neuron.sv
// ----------------------------------------------------------------------------
// pwt_neuron
// Weight store, weighted sum, prediction and saturating weight update.
// ----------------------------------------------------------------------------
`include "perceptron_window_trainer_unit_assert.svh"

module pwt_neuron #(
  parameter int WEIGHT_WIDTH = pwt_pkg::DEF_WEIGHT_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  pwt_pkg::cfg_t     cfg,
  input  logic              fire,
  input  pwt_pkg::item_t    item,
  output pwt_pkg::result_t  res
);

  localparam int SUM_WIDTH = WEIGHT_WIDTH + 4;

  logic signed [WEIGHT_WIDTH-1:0] weights      [pwt_pkg::NUM_WEIGHTS];
  logic signed [WEIGHT_WIDTH-1:0] weights_next [pwt_pkg::NUM_WEIGHTS];
  logic [pwt_pkg::NUM_WEIGHTS-1:0] upd_en;
  logic signed [SUM_WIDTH-1:0]    sum;
  logic signed [WEIGHT_WIDTH:0]   step_pos;
  logic signed [WEIGHT_WIDTH:0]   step_neg;
  logic                           predicted;
  logic                           mismatch;
  logic                           do_train;
  logic                           err_seen;

  function automatic logic signed [WEIGHT_WIDTH-1:0] sat_add(
    input logic signed [WEIGHT_WIDTH-1:0] w,
    input logic signed [WEIGHT_WIDTH:0]   delta
  );
    logic signed [WEIGHT_WIDTH:0] ext;
    ext = {w[WEIGHT_WIDTH-1], w} + delta;
    if (ext[WEIGHT_WIDTH] != ext[WEIGHT_WIDTH-1]) begin
      sat_add = ext[WEIGHT_WIDTH] ? {1'b1, {(WEIGHT_WIDTH-1){1'b0}}}
                                  : {1'b0, {(WEIGHT_WIDTH-1){1'b1}}};
    end else begin
      sat_add = ext[WEIGHT_WIDTH-1:0];
    end
  endfunction

  // Bias input is -1, so weight 0 enters negated.
  always_comb begin
    sum = -SUM_WIDTH'(weights[0]);
    for (int i = 1; i < pwt_pkg::NUM_WEIGHTS; i++) begin
      if (item.bits[i-1]) begin
        sum = sum + SUM_WIDTH'(weights[i]);
      end
    end
  end

  assign predicted = !sum[SUM_WIDTH-1] && (sum != '0);
  assign mismatch  = predicted ^ item.goal;
  assign do_train  = fire && mismatch && cfg.train_enable;

  assign step_pos = $signed({{(WEIGHT_WIDTH+1-pwt_pkg::LR_WIDTH){1'b0}}, cfg.learn_rate});
  assign step_neg = -step_pos;

  // On a mismatch the goal gives the direction: goal 1 raises active weights.
  always_comb begin
    upd_en[0]       = 1'b1;
    weights_next[0] = sat_add(weights[0], item.goal ? step_neg : step_pos);
    for (int i = 1; i < pwt_pkg::NUM_WEIGHTS; i++) begin
      upd_en[i]       = item.bits[i-1];
      weights_next[i] = sat_add(weights[i], item.goal ? step_pos : step_neg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pwt_pkg::NUM_WEIGHTS; i++) begin
        weights[i] <= '0;
      end
    end else if (do_train) begin
      for (int i = 0; i < pwt_pkg::NUM_WEIGHTS; i++) begin
        if (upd_en[i]) begin
          weights[i] <= weights_next[i];
        end
      end
    end
  end

  // Gather mismatches; clear on the epoch's last word.
  always_ff @(posedge clk) begin
    if (rst) begin
      err_seen <= 1'b0;
    end else if (fire) begin
      if (item.epoch_end) begin
        err_seen <= 1'b0;
      end else if (mismatch) begin
        err_seen <= 1'b1;
      end
    end
  end

  assign res.predicted       = predicted;
  assign res.mismatch        = mismatch;
  assign res.epoch_had_error = item.epoch_end && (err_seen || mismatch);

  `PWT_ASSERT_NEXT(a_epoch_clears, fire && item.epoch_end, !err_seen, "epoch flag not cleared")
  `PWT_ASSERT_NEXT(a_no_train_hold, fire && !cfg.train_enable, $stable(weights[0]), "bias weight moved with training off")
  `PWT_ASSERT_NEXT(a_hit_hold, fire && !mismatch, $stable(weights[0]), "bias weight moved on a correct prediction")

endmodule

// File: dv/perceptron_window_trainer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// perceptron_window_trainer_unit_tb
// Self-checking bench for the window perceptron trainer. A short table of
// directed words and register writes runs first. Phases of training-set
// epochs with random pixel content and some noise words follow. Every
// accepted word runs through a local copy of the classifier and its weight
// update. Results are compared in order, with random gaps and stalls on
// both channels outside the last two phases.
// ----------------------------------------------------------------------------
module perceptron_window_trainer_unit_tb;
  import pwt_pkg::*;

  localparam int WEIGHT_WIDTH = DEF_WEIGHT_WIDTH;
  localparam longint W_MAX = (longint'(1) << (WEIGHT_WIDTH - 1)) - 1;
  localparam longint W_MIN = -(longint'(1) << (WEIGHT_WIDTH - 1));
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam int NUM_PHASES = 13;
  localparam int WORDS_PER_PHASE = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT = 2000;

  typedef logic [NUM_PIX-1:0][PIX_WIDTH-1:0] window_t;

  typedef struct packed {
    logic                       is_write;
    logic [CFG_INDEX_WIDTH-1:0] reg_idx;
    logic [CFG_DATA_WIDTH-1:0]  reg_val;
    window_t                    win;
    logic [PIX_WIDTH-1:0]       goal;
    logic                       eend;
    logic                       typed;
    result_t                    want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [PIX_WIDTH-1:0] pix_up_left, pix_up, pix_up_right;
  logic [PIX_WIDTH-1:0] pix_left, pix_center, pix_right;
  logic [PIX_WIDTH-1:0] pix_down_left, pix_down, pix_down_right;
  logic [PIX_WIDTH-1:0] goal_pixel;
  logic epoch_end;
  logic out_valid;
  logic out_stall;
  logic predicted;
  logic mismatch;
  logic epoch_had_error;

  // local copy of the block's state and registers
  logic signed [WEIGHT_WIDTH-1:0] trained_weight [NUM_WEIGHTS];
  logic epoch_error_flag;
  cfg_t shadow;

  result_t pending_results [$];
  plan_row_t directed_plan [$];
  result_t want_r;
  int error_count = 0;
  int quiet_cycles = 0;
  bit gaps_on = 1'b1;

  perceptron_window_trainer_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pix_up_left    (pix_up_left),
    .pix_up         (pix_up),
    .pix_up_right   (pix_up_right),
    .pix_left       (pix_left),
    .pix_center     (pix_center),
    .pix_right      (pix_right),
    .pix_down_left  (pix_down_left),
    .pix_down       (pix_down),
    .pix_down_right (pix_down_right),
    .goal_pixel     (goal_pixel),
    .epoch_end      (epoch_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .predicted      (predicted),
    .mismatch       (mismatch),
    .epoch_had_error(epoch_had_error)
  );

  always #1 clk = ~clk;

  function automatic longint clamp_weight(input longint v);
    if (v > W_MAX) return W_MAX;
    if (v < W_MIN) return W_MIN;
    return v;
  endfunction

  // Classify one window, apply the learning rule and track the epoch flag.
  task automatic classify_and_train(input window_t win, input logic [PIX_WIDTH-1:0] goal,
                                    input logic eend, output result_t res);
    logic [NUM_WEIGHTS-1:0] x;
    logic goal_bit;
    logic guess;
    longint acc;
    longint w;
    longint step;
    x[0] = 1'b1;  // bias input, contributes -weight
    for (int k = 1; k < NUM_WEIGHTS; k++) x[k] = win[k-1] > shadow.threshold_level;
    goal_bit = goal > shadow.threshold_level;
    w = longint'(trained_weight[0]);
    acc = -w;
    for (int k = 1; k < NUM_WEIGHTS; k++) begin
      w = longint'(trained_weight[k]);
      if (x[k]) acc += w;
    end
    guess = acc > 0;
    if (guess != goal_bit && shadow.train_enable) begin
      step = goal_bit ? longint'(shadow.learn_rate) : -longint'(shadow.learn_rate);
      w = longint'(trained_weight[0]);
      trained_weight[0] = WEIGHT_WIDTH'(clamp_weight(w - step));
      for (int k = 1; k < NUM_WEIGHTS; k++) begin
        w = longint'(trained_weight[k]);
        if (x[k]) trained_weight[k] = WEIGHT_WIDTH'(clamp_weight(w + step));
      end
    end
    if (guess != goal_bit) epoch_error_flag = 1'b1;
    res.predicted = guess;
    res.mismatch = guess != goal_bit;
    res.epoch_had_error = eend ? epoch_error_flag : 1'b0;
    if (eend) epoch_error_flag = 1'b0;
  endtask

  // Pixel value that binarises to the wanted bit, unless a one is wanted at level 255; boundary values favoured.
  function automatic logic [PIX_WIDTH-1:0] pixel_for(input logic one);
    logic [PIX_WIDTH-1:0] thr;
    thr = shadow.threshold_level;
    if (one) begin
      if (thr == 8'hFF) return 8'hFF;  // nothing lies above
      if ($urandom_range(0, 3) == 0) return thr + 8'd1;
      return 8'($urandom_range(255, thr + 1));
    end
    if ($urandom_range(0, 3) == 0) return thr;
    return 8'($urandom_range(thr, 0));
  endfunction

  function automatic void plan_word(input window_t win, input logic [PIX_WIDTH-1:0] goal,
                                    input logic eend, input logic typed, input result_t want);
    plan_row_t r;
    r = '0;
    r.win = win;
    r.goal = goal;
    r.eend = eend;
    r.typed = typed;
    r.want = want;
    directed_plan.push_back(r);
  endfunction

  function automatic void plan_write(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                     input logic [CFG_DATA_WIDTH-1:0] val);
    plan_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    directed_plan.push_back(r);
  endfunction

  task automatic send_word(input window_t win, input logic [PIX_WIDTH-1:0] goal,
                           input logic eend, input logic typed, input result_t want);
    result_t got;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    pix_up_left    <= win[0];
    pix_up         <= win[1];
    pix_up_right   <= win[2];
    pix_left       <= win[3];
    pix_center     <= win[4];
    pix_right      <= win[5];
    pix_down_left  <= win[6];
    pix_down       <= win[7];
    pix_down_right <= win[8];
    goal_pixel     <= goal;
    epoch_end      <= eend;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    classify_and_train(win, goal, eend, got);
    pending_results.push_back(typed ? want : got);
  endtask

  // Drop valid and wait until every expected word has come back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_THRESHOLD:    shadow.threshold_level = val[PIX_WIDTH-1:0];
      CFG_LEARN_RATE:   shadow.learn_rate = val[LR_WIDTH-1:0];
      CFG_TRAIN_ENABLE: shadow.train_enable = val[0];
      default: ;
    endcase
  endtask

  // Receiver stalls in bursts.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result word %0b%0b%0b", $time,
                   predicted, mismatch, epoch_had_error);
          error_count++;
        end else begin
          want_r = pending_results.pop_front();
          if (predicted !== want_r.predicted) begin
            $display("%0t: predicted expected %0b got %0b", $time,
                     want_r.predicted, predicted);
            error_count++;
          end
          if (mismatch !== want_r.mismatch) begin
            $display("%0t: mismatch expected %0b got %0b", $time,
                     want_r.mismatch, mismatch);
            error_count++;
          end
          if (epoch_had_error !== want_r.epoch_had_error) begin
            $display("%0t: epoch_had_error expected %0b got %0b", $time,
                     want_r.epoch_had_error, epoch_had_error);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    window_t win;
    logic [NUM_PIX-1:0] proto_bits [8];
    logic proto_goal [8];
    logic [NUM_PIX-1:0] rule_mask;
    logic [PIX_WIDTH-1:0] thr;
    logic [LR_WIDTH-1:0] lr;
    logic te;
    int n_proto;
    int pos;
    bit or_rule;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_data = '0;
    in_valid = 1'b0;
    pix_up_left = '0;
    pix_up = '0;
    pix_up_right = '0;
    pix_left = '0;
    pix_center = '0;
    pix_right = '0;
    pix_down_left = '0;
    pix_down = '0;
    pix_down_right = '0;
    goal_pixel = '0;
    epoch_end = 1'b0;
    for (int k = 0; k < NUM_WEIGHTS; k++) trained_weight[k] = '0;
    epoch_error_flag = 1'b0;
    shadow = '{THRESHOLD_RESET, LEARN_RATE_RESET, TRAIN_ENABLE_RESET};

    // zero weights: zero sum predicts 0
    plan_word('0, 8'd0, 1'b0, 1'b1, '0);
    plan_word({NUM_PIX{8'hFF}}, 8'd0, 1'b1, 1'b1, '0);
    // just above the default level: all ones, first miss
    plan_word({NUM_PIX{8'd128}}, 8'd128, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b0});
    plan_word({NUM_PIX{8'd127}}, 8'd127, 1'b1, 1'b0, '0);
    // top level: nothing binarises to one; excess data bits masked
    plan_write(CFG_THRESHOLD, 12'hFFF);
    plan_word({NUM_PIX{8'hFF}}, 8'hFF, 1'b1, 1'b0, '0);
    plan_write(CFG_UNUSED_INDEX, 12'h000);
    plan_word({NUM_PIX{8'hFF}}, 8'hFF, 1'b0, 1'b0, '0);
    // one-hot windows at the largest step
    plan_write(CFG_THRESHOLD, 12'h000);
    plan_write(CFG_LEARN_RATE, 12'hFFF);
    for (int k = 0; k < NUM_PIX; k++) begin
      win = '0;
      win[k] = 8'd1;
      plan_word(win, 8'd1, k == NUM_PIX - 1, 1'b0, '0);
    end
    // training off: misses reported, weights hold
    plan_write(CFG_TRAIN_ENABLE, 12'hFFE);
    plan_word({NUM_PIX{8'hFF}}, 8'd0, 1'b0, 1'b0, '0);
    plan_word({NUM_PIX{8'hFF}}, 8'd0, 1'b1, 1'b0, '0);
    plan_write(CFG_TRAIN_ENABLE, 12'h001);
    plan_write(CFG_LEARN_RATE, 12'h000);
    plan_word({NUM_PIX{8'hFF}}, 8'd0, 1'b1, 1'b0, '0);
    plan_word({NUM_PIX{8'hFF}}, 8'd0, 1'b1, 1'b0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_write) begin
        settle();
        write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
      end else begin
        send_word(directed_plan[i].win, directed_plan[i].goal, directed_plan[i].eend,
                  directed_plan[i].typed, directed_plan[i].want);
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      gaps_on = phase < NUM_PHASES - 2;
      case (phase)
        0: begin
          thr = 8'd0;
          lr = 12'hFFF;
          te = 1'b1;
        end
        1: begin
          thr = 8'hFF;
          lr = 12'd0;
          te = 1'b0;
        end
        default: begin
          if ($urandom_range(0, 3) == 0) thr = $urandom_range(0, 1) ? 8'hFF : 8'd0;
          else thr = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 3) == 0) lr = $urandom_range(0, 1) ? 12'hFFF : 12'd0;
          else lr = 12'($urandom_range(0, 4095));
          te = $urandom_range(0, 3) != 0;
        end
      endcase
      write_reg(CFG_THRESHOLD, {4'($urandom), thr});
      write_reg(CFG_LEARN_RATE, lr);
      write_reg(CFG_TRAIN_ENABLE, {11'($urandom), te});

      // small training set; each phase picks at random whether to use a separable OR rule
      n_proto = $urandom_range(2, 8);
      or_rule = $urandom_range(0, 1);
      rule_mask = 9'($urandom);
      for (int p = 0; p < n_proto; p++) begin
        proto_bits[p] = 9'($urandom);
        proto_goal[p] = or_rule ? |(proto_bits[p] & rule_mask) : 1'($urandom);
      end
      pos = 0;
      for (int w = 0; w < WORDS_PER_PHASE; w++) begin
        if ($urandom_range(0, 9) == 0) begin
          for (int p = 0; p < NUM_PIX; p++) win[p] = 8'($urandom_range(0, 255));
          send_word(win, 8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0, 1'b0, '0);
        end else begin
          for (int p = 0; p < NUM_PIX; p++) win[p] = pixel_for(proto_bits[pos][p]);
          send_word(win, pixel_for(proto_goal[pos]), pos == n_proto - 1, 1'b0, '0);
          pos = (pos + 1) % n_proto;
        end
      end
    end

    settle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/pwt_pkg.sv
src/pwt_in_stage.sv
src/pwt_neuron.sv
src/perceptron_window_trainer_unit.sv
dv/perceptron_window_trainer_unit_tb.sv
